>>> rtl/lpr_pkg.sv
// Shared types, codes and helpers for the IPv4 longest-prefix route table.
`default_nettype none

package lpr_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	// Operation codes.
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_LOOKUP = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_FIND   = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADIDX = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] key_addr;
		logic [31:0] key_mask;
		logic [31:0] next_hop;
		logic [7:0]  iface_id;
		logic [7:0]  slot;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot_out;
		logic [31:0] route_subnet;
		logic [31:0] route_mask;
		logic [31:0] route_gateway;
		logic [7:0]  route_iface;
		logic [5:0]  prefix_len;
	} rsp_t;

	// One stored route as it sits in the table memory.
	typedef struct packed {
		logic [31:0] subnet;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [7:0]  iface;
	} route_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic walk_rd;
		logic slot_rd;
		logic commit;
		logic rsp_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] op;
		logic       slot_bad;
		logic       walk_last;
	} sts_t;

	// Population count as a five-level tree of field-wise adds.
	function automatic logic [5:0] popcount32(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		a = (v & 32'h5555_5555) + ((v >> 1) & 32'h5555_5555);
		b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
		c = (b & 32'h0F0F_0F0F) + ((b >> 4) & 32'h0F0F_0F0F);
		d = (c & 32'h00FF_00FF) + ((c >> 8) & 32'h00FF_00FF);
		e = (d & 32'h0000_FFFF) + ((d >> 16) & 32'h0000_FFFF);
		return e[5:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/lpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lpr_ctrl.sv
// Controller state machine that sequences each request of the route table.
`default_nettype none

module lpr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	input  wire lpr_pkg::sts_t sts,
	output lpr_pkg::cmd_t      cmd
);

	import lpr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_SETTLE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_DECODE: begin
				cmd.slot_rd = ((sts.op == OP_GET) || (sts.op == OP_REMOVE)) && !sts.slot_bad;
			end
			S_WALK: begin
				cmd.walk_rd = 1'b1;
			end
			S_SETTLE: begin
				cmd = '0;
			end
			S_FINISH: begin
				cmd.commit   = rsp_free;
				cmd.rsp_load = rsp_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (sts.op)
						OP_ADD, OP_LOOKUP, OP_FIND: begin
							state_q <= S_WALK;
						end
						OP_GET, OP_REMOVE: begin
							state_q <= sts.slot_bad ? S_FINISH : S_SETTLE;
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_WALK: begin
					if (sts.walk_last) begin
						state_q <= S_SETTLE;
					end
				end
				S_SETTLE: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/lpr_datapath.sv
// Datapath: request register, table memory, valid bits, slot compare and result register.
`default_nettype none

module lpr_datapath #(
	parameter int TABLE_DEPTH = lpr_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lpr_pkg::req_t req,
	input  wire lpr_pkg::cmd_t cmd,
	output lpr_pkg::sts_t      sts,
	output lpr_pkg::rsp_t      rsp
);

	import lpr_pkg::*;

	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ROUTE_W = $bits(route_t);

	req_t             req_q;
	rsp_t             rsp_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             rd_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] best_idx_q;
	route_t           best_route_q;
	logic [5:0]       best_len_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	route_t           ram_route;
	route_t           req_route;
	logic [5:0]       ram_len;
	logic [5:0]       req_len;
	logic             cand_hit;
	logic             slot_bad;
	logic             add_wr;
	logic [1:0]       status;

	assign slot_bad  = ({1'b0, req_q.slot} >= 9'(TABLE_DEPTH));
	assign rd_en     = cmd.walk_rd || cmd.slot_rd;
	assign rd_addr   = cmd.walk_rd ? idx_q : req_q.slot[IDX_W-1:0];
	assign req_route = '{subnet: req_q.key_addr, mask: req_q.key_mask,
		gateway: req_q.next_hop, iface: req_q.iface_id};
	assign ram_len   = popcount32(ram_route.mask);
	assign req_len   = popcount32(req_q.key_mask);
	assign add_wr    = cmd.commit && (req_q.operation == OP_ADD) && hit_q;

	assign sts.op        = req_q.operation;
	assign sts.slot_bad  = slot_bad;
	assign sts.walk_last = (idx_q == IDX_W'(TABLE_DEPTH - 1));

	lpr_ram #(
		.WIDTH (ROUTE_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (add_wr),
		.waddr (best_idx_q),
		.wdata (req_route),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_route)
	);

	// Decide whether the slot read last cycle becomes the new answer.
	always_comb begin
		cand_hit = 1'b0;
		if (rd_s1) begin
			unique case (req_q.operation)
				OP_ADD: begin
					cand_hit = !vld_s1 && !hit_q;
				end
				OP_LOOKUP: begin
					cand_hit = vld_s1 && ((req_q.key_addr & ram_route.mask) == ram_route.subnet)
						&& (!hit_q || (ram_len > best_len_q));
				end
				OP_FIND: begin
					cand_hit = vld_s1 && !hit_q && (ram_route.subnet == req_q.key_addr)
						&& (ram_route.mask == req_q.key_mask);
				end
				OP_GET, OP_REMOVE: begin
					cand_hit = vld_s1;
				end
				default: begin
					cand_hit = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		unique case (req_q.operation)
			OP_ADD: begin
				status = hit_q ? ST_OK : ST_FULL;
			end
			OP_GET, OP_REMOVE: begin
				status = slot_bad ? ST_BADIDX : (hit_q ? ST_OK : ST_NONE);
			end
			OP_LOOKUP, OP_FIND: begin
				status = hit_q ? ST_OK : ST_NONE;
			end
			default: begin
				status = ST_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q   <= '0;
			rd_s1   <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.walk_rd) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cand_hit) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit && hit_q) begin
				if (req_q.operation == OP_ADD) begin
					valid_q[best_idx_q] <= 1'b1;
				end else if (req_q.operation == OP_REMOVE) begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (rd_en) begin
			idx_s1 <= rd_addr;
			vld_s1 <= valid_q[rd_addr];
		end
		if (cand_hit) begin
			best_idx_q <= idx_s1;
			if (req_q.operation == OP_ADD) begin
				best_route_q <= req_route;
				best_len_q   <= req_len;
			end else begin
				best_route_q <= ram_route;
				best_len_q   <= ram_len;
			end
		end
		if (cmd.rsp_load) begin
			if (status == ST_OK) begin
				rsp_q.status        <= ST_OK;
				rsp_q.slot_out      <= 8'(best_idx_q);
				rsp_q.route_subnet  <= best_route_q.subnet;
				rsp_q.route_mask    <= best_route_q.mask;
				rsp_q.route_gateway <= best_route_q.gateway;
				rsp_q.route_iface   <= best_route_q.iface;
				rsp_q.prefix_len    <= best_len_q;
			end else begin
				rsp_q.status        <= status;
				rsp_q.slot_out      <= '0;
				rsp_q.route_subnet  <= '0;
				rsp_q.route_mask    <= '0;
				rsp_q.route_gateway <= '0;
				rsp_q.route_iface   <= '0;
				rsp_q.prefix_len    <= '0;
			end
		end
	end

	assign rsp = rsp_q;

	// A result must not be taken while a slot compare is still in flight.
	a_commit_after_compare: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rd_s1)
		else $error("commit issued while a slot compare is pending");

	a_no_bad_slot_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_rd |-> !slot_bad)
		else $error("table read issued for an out-of-range slot");

	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		add_wr |=> valid_q[$past(best_idx_q)])
		else $error("added route did not become valid");

	a_one_read_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.walk_rd && cmd.slot_rd))
		else $error("walk read and slot read issued together");

endmodule

`default_nettype wire

>>> rtl/ipv4_longest_prefix_route_table.sv
// IPv4 route table with add, remove, get, find and longest-prefix lookup.
// Usage:
//   A request arrives on req (valid/stall); one result leaves on rsp for each request.
//   The block takes one request at a time: req_stall is high from acceptance until
//   the result has been loaded into the output register.
//   Add, lookup and find walk the table one slot per cycle through the table
//   memory's single read port, then settle and finish; the next request is taken
//   once the block is back in idle.
//   Get and remove read one slot: decode, settle and finish.
//   A bad index or an unknown operation goes from decode straight to finish.
//   Reset clears all valid bits, so the table starts empty; route data is not cleared.
//   When the receiver stalls, the result holds in the output register and the block
//   may already accept and work on the next request; it waits only to hand over
//   that next result until the register is free.
`default_nettype none

module ipv4_longest_prefix_route_table #(
	parameter int TABLE_DEPTH = lpr_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lpr_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output lpr_pkg::rsp_t      rsp
);

	import lpr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpr_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
